@@ src/tdl_pkg.sv @@
// Shared types and constants of the text lexer: character classes, token
// kinds, lexer states and the record passed from the lexer core to the result stage.
// No dependencies.
package tdl_pkg;

  localparam int TOK_W = 16;
  localparam logic [TOK_W-1:0] LEN_MAX = 16'hFFFF;
  localparam int CLS_W = 4;

  typedef enum logic [2:0] {
    K_NUM   = 3'd0,
    K_WORD  = 3'd1,
    K_SPACE = 3'd2,
    K_PUNCT = 3'd3,
    K_OPER  = 3'd4,
    K_UNM   = 3'd5
  } kind_t;

  // Character classes; each byte falls in exactly one.
  typedef enum logic [CLS_W-1:0] {
    C_DIGIT,   // 0-9
    C_DOT,     // '.'
    C_LETTER,  // A-Z a-z
    C_WSYM,    // '_' '-'
    C_SPACE,   // ' '
    C_PUNCT,   // , ? ! : ; ( )
    C_TAB,     // tab: punctuation, not quotable
    C_OPQ,     // '*' '=': operator and quotable
    C_OPER,    // '<' '>'
    C_QUOTE,   // double or single quote
    C_QSYM,    // + @ # $ % ^ &: quotable only
    C_OTHER
  } char_class_t;

  typedef enum logic [3:0] {
    L_IDLE, L_INT, L_INT_DOT, L_LEAD_DOT, L_FRAC,
    L_WORD, L_SPACE, L_PUNCT, L_OPER, L_QUOTE
  } lex_state_t;

  typedef enum logic [2:0] {
    P_WAIT, P_FETCH, P_EXEC, P_FINAL, P_DONE
  } phase_t;

  typedef struct packed {
    char_class_t cls;
    logic        eot;
  } item_t;

  typedef struct packed {
    logic             emit;
    logic             done;
    kind_t            kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] len;
  } emit_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    case (c) inside
      ["0":"9"]:                              r = C_DIGIT;
      8'h2E:                                  r = C_DOT;
      ["A":"Z"], ["a":"z"]:                   r = C_LETTER;
      8'h5F, 8'h2D:                           r = C_WSYM;
      8'h20:                                  r = C_SPACE;
      8'h2C, 8'h3F, 8'h21, 8'h3A, 8'h3B,
      8'h28, 8'h29:                           r = C_PUNCT;
      8'h09:                                  r = C_TAB;
      8'h2A, 8'h3D:                           r = C_OPQ;
      8'h3C, 8'h3E:                           r = C_OPER;
      8'h22, 8'h27:                           r = C_QUOTE;
      8'h2B, 8'h40, 8'h23, 8'h24, 8'h25,
      8'h5E, 8'h26:                           r = C_QSYM;
      default:                                r = C_OTHER;
    endcase
    return r;
  endfunction

endpackage

@@ src/tdl_if.sv @@
// Valid/ready channel interfaces for characters in and tokens out.
// No dependencies.
interface tdl_chars_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface tdl_tokens_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

@@ src/tdl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tdl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ src/tdl_front.sv @@
// Front end: accept characters, classify them and hold them in a two-entry queue.
// Depends on tdl_pkg and tdl_if.
module tdl_front (
  input  logic             clk,
  input  logic             rst,
  tdl_chars_if.sink        chars,
  output tdl_pkg::item_t   item,
  output logic             item_valid,
  input  logic             item_pop
);
  tdl_pkg::item_t q [2];
  logic [1:0] count;
  logic push;

  assign chars.ready = (count != 2'd2);
  assign push        = chars.valid && chars.ready;
  assign item        = q[0];
  assign item_valid  = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, item_pop};
    end
  end

  // Shift on pop; write the new item behind what remains.
  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || (count == 2'd1 && item_pop)))
      q[0] <= '{cls: tdl_pkg::classify(chars.char_code), eot: chars.end_of_text};
    else if (item_pop)
      q[0] <= q[1];
    if (push && count == 2'd1 && !item_pop)
      q[1] <= '{cls: tdl_pkg::classify(chars.char_code), eot: chars.end_of_text};
  end
endmodule

@@ src/tdl_core.sv @@
// Back end: longest-match lexer state machine over classified characters,
// with a class history RAM that replays characters after a failed quote.
// Depends on tdl_pkg and tdl_ram.
module tdl_core #(
  parameter int REPLAY_DEPTH = 32,
  parameter int POS_BITS     = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  tdl_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_pop,
  output tdl_pkg::emit_t em,
  input  logic           out_rdy
);
  localparam int IDX_W = $clog2(REPLAY_DEPTH);
  localparam int CNT_W = $clog2(REPLAY_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLAY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(REPLAY_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [IDX_W-1:0]    idx_t;

  function automatic idx_t idx_inc(input idx_t x);
    return (x == IDX_LAST) ? '0 : x + 1'b1;
  endfunction

  tdl_pkg::phase_t      phase, phase_next;
  tdl_pkg::lex_state_t  mstate, mstate_next;
  tdl_pkg::kind_t       last_kind, last_kind_next;
  tdl_pkg::char_class_t head_cls, head_cls_next, cls;
  pos_t tok_begin, tok_begin_next, cur_pos, cur_pos_next, last_pos, last_pos_next;
  logic [tdl_pkg::TOK_W-1:0] run_len, run_len_next;
  logic [CNT_W-1:0] qcount, qcount_next;
  idx_t qseq, qseq_next, wr_idx, wr_idx_next, rd_idx, rd_idx_next, rd_n;
  logic eot, eot_next, from_ram, from_ram_next;
  logic ram_we, ram_re, consume, rewind;
  logic [tdl_pkg::CLS_W-1:0] ram_q;
  logic [tdl_pkg::TOK_W:0] run_plus2;
  logic [tdl_pkg::TOK_W-1:0] run_inc;

  tdl_ram #(.WIDTH(tdl_pkg::CLS_W), .DEPTH(REPLAY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (item.cls),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  assign cls       = from_ram ? tdl_pkg::char_class_t'(ram_q) : head_cls;
  assign run_plus2 = {1'b0, run_len} + 17'd2;
  assign run_inc   = (run_len == tdl_pkg::LEN_MAX) ? run_len : run_len + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tdl_pkg::P_WAIT;
      mstate    <= tdl_pkg::L_IDLE;
      last_kind <= tdl_pkg::K_NUM;
      tok_begin <= '0;
      cur_pos   <= '0;
      last_pos  <= '0;
      run_len   <= '0;
      qcount    <= '0;
      qseq      <= '0;
      wr_idx    <= '0;
      rd_idx    <= '0;
      eot       <= 1'b0;
      from_ram  <= 1'b0;
    end else begin
      phase     <= phase_next;
      mstate    <= mstate_next;
      last_kind <= last_kind_next;
      tok_begin <= tok_begin_next;
      cur_pos   <= cur_pos_next;
      last_pos  <= last_pos_next;
      run_len   <= run_len_next;
      qcount    <= qcount_next;
      qseq      <= qseq_next;
      wr_idx    <= wr_idx_next;
      rd_idx    <= rd_idx_next;
      eot       <= eot_next;
      from_ram  <= from_ram_next;
    end
  end

  always_ff @(posedge clk) begin
    head_cls <= head_cls_next;
  end

  always_comb begin
    phase_next     = phase;
    mstate_next    = mstate;
    last_kind_next = last_kind;
    tok_begin_next = tok_begin;
    cur_pos_next   = cur_pos;
    last_pos_next  = last_pos;
    run_len_next   = run_len;
    qcount_next    = qcount;
    qseq_next      = qseq;
    wr_idx_next    = wr_idx;
    rd_idx_next    = rd_idx;
    eot_next       = eot;
    from_ram_next  = from_ram;
    head_cls_next  = head_cls;
    rd_n           = rd_idx;
    em             = '0;
    item_pop       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    consume        = 1'b0;
    rewind         = 1'b0;

    case (phase)
      tdl_pkg::P_WAIT: begin
        if (item_valid) begin
          item_pop      = 1'b1;
          ram_we        = 1'b1;
          wr_idx_next   = idx_inc(wr_idx);
          head_cls_next = item.cls;
          eot_next      = item.eot;
          from_ram_next = 1'b0;
          phase_next    = tdl_pkg::P_EXEC;
        end
      end

      tdl_pkg::P_FETCH: begin
        ram_re        = 1'b1;
        from_ram_next = 1'b1;
        phase_next    = tdl_pkg::P_EXEC;
      end

      tdl_pkg::P_EXEC: begin
        if (out_rdy) begin
          case (mstate)
            tdl_pkg::L_IDLE: begin
              consume        = 1'b1;
              tok_begin_next = cur_pos;
              last_pos_next  = cur_pos;
              run_len_next   = 16'd1;
              case (cls)
                tdl_pkg::C_DIGIT: begin
                  mstate_next = tdl_pkg::L_INT; last_kind_next = tdl_pkg::K_NUM;
                end
                tdl_pkg::C_DOT: begin
                  mstate_next = tdl_pkg::L_LEAD_DOT; last_kind_next = tdl_pkg::K_PUNCT;
                end
                tdl_pkg::C_LETTER, tdl_pkg::C_WSYM: begin
                  mstate_next = tdl_pkg::L_WORD; last_kind_next = tdl_pkg::K_WORD;
                end
                tdl_pkg::C_SPACE: begin
                  mstate_next = tdl_pkg::L_SPACE; last_kind_next = tdl_pkg::K_SPACE;
                end
                tdl_pkg::C_PUNCT, tdl_pkg::C_TAB: begin
                  mstate_next = tdl_pkg::L_PUNCT; last_kind_next = tdl_pkg::K_PUNCT;
                end
                tdl_pkg::C_OPQ, tdl_pkg::C_OPER: begin
                  mstate_next = tdl_pkg::L_OPER; last_kind_next = tdl_pkg::K_OPER;
                end
                tdl_pkg::C_QUOTE: begin
                  // Open a quote; only the begin position matters here.
                  mstate_next    = tdl_pkg::L_QUOTE;
                  last_kind_next = last_kind;
                  last_pos_next  = last_pos;
                  run_len_next   = run_len;
                  qcount_next    = CNT_W'(1);
                  qseq_next      = rd_idx;
                end
                default: begin
                  tok_begin_next = tok_begin;
                  last_pos_next  = last_pos;
                  run_len_next   = run_len;
                  em.emit  = 1'b1;
                  em.kind  = tdl_pkg::K_UNM;
                  em.start = tdl_pkg::TOK_W'(cur_pos);
                  em.len   = 16'd1;
                end
              endcase
            end

            tdl_pkg::L_INT: begin
              if (cls == tdl_pkg::C_DIGIT) begin
                consume = 1'b1; last_pos_next = cur_pos; run_len_next = run_inc;
              end else if (cls == tdl_pkg::C_DOT) begin
                consume = 1'b1; mstate_next = tdl_pkg::L_INT_DOT;
              end else begin
                em.emit = 1'b1; em.kind = last_kind;
                em.start = tdl_pkg::TOK_W'(tok_begin); em.len = run_len;
                mstate_next = tdl_pkg::L_IDLE;
              end
            end

            tdl_pkg::L_INT_DOT: begin
              if (cls == tdl_pkg::C_DIGIT) begin
                consume       = 1'b1;
                run_len_next  = run_plus2[tdl_pkg::TOK_W] ? tdl_pkg::LEN_MAX
                                                          : run_plus2[tdl_pkg::TOK_W-1:0];
                last_pos_next = cur_pos;
                mstate_next   = tdl_pkg::L_FRAC;
              end else begin
                // Digits stand as a number; the dot opens a punctuation run.
                em.emit = 1'b1; em.kind = tdl_pkg::K_NUM;
                em.start = tdl_pkg::TOK_W'(tok_begin); em.len = run_len;
                mstate_next    = tdl_pkg::L_PUNCT;
                last_kind_next = tdl_pkg::K_PUNCT;
                tok_begin_next = cur_pos - 1'b1;
                last_pos_next  = cur_pos - 1'b1;
                run_len_next   = 16'd1;
              end
            end

            tdl_pkg::L_LEAD_DOT: begin
              if (cls == tdl_pkg::C_DIGIT) begin
                consume        = 1'b1;
                mstate_next    = tdl_pkg::L_FRAC;
                last_kind_next = tdl_pkg::K_NUM;
                last_pos_next  = cur_pos;
                run_len_next   = 16'd2;
              end else begin
                mstate_next = tdl_pkg::L_PUNCT;
              end
            end

            tdl_pkg::L_FRAC, tdl_pkg::L_WORD, tdl_pkg::L_SPACE,
            tdl_pkg::L_PUNCT, tdl_pkg::L_OPER: begin
              if ((mstate == tdl_pkg::L_FRAC  && cls == tdl_pkg::C_DIGIT) ||
                  (mstate == tdl_pkg::L_WORD  && (cls == tdl_pkg::C_LETTER ||
                                                  cls == tdl_pkg::C_WSYM)) ||
                  (mstate == tdl_pkg::L_SPACE && cls == tdl_pkg::C_SPACE) ||
                  (mstate == tdl_pkg::L_PUNCT && (cls == tdl_pkg::C_DOT ||
                                                  cls == tdl_pkg::C_PUNCT ||
                                                  cls == tdl_pkg::C_TAB)) ||
                  (mstate == tdl_pkg::L_OPER  && (cls == tdl_pkg::C_OPQ ||
                                                  cls == tdl_pkg::C_OPER))) begin
                consume = 1'b1; last_pos_next = cur_pos; run_len_next = run_inc;
              end else begin
                em.emit = 1'b1; em.kind = last_kind;
                em.start = tdl_pkg::TOK_W'(tok_begin); em.len = run_len;
                mstate_next = tdl_pkg::L_IDLE;
              end
            end

            tdl_pkg::L_QUOTE: begin
              if (cls == tdl_pkg::C_QUOTE) begin
                consume = 1'b1;
                em.emit = 1'b1; em.kind = tdl_pkg::K_WORD;
                em.start = tdl_pkg::TOK_W'(tok_begin + 1'b1);
                em.len = tdl_pkg::TOK_W'(qcount - 1'b1);
                qcount_next = '0;
                mstate_next = tdl_pkg::L_IDLE;
              end else if (cls == tdl_pkg::C_LETTER || cls == tdl_pkg::C_DOT ||
                           cls == tdl_pkg::C_WSYM || cls == tdl_pkg::C_SPACE ||
                           cls == tdl_pkg::C_PUNCT || cls == tdl_pkg::C_OPQ ||
                           cls == tdl_pkg::C_QSYM) begin
                if (qcount + 1'b1 == CNT_FULL) begin
                  // Quote would overrun the buffer: fail it and replay.
                  rewind = 1'b1;
                end else begin
                  consume = 1'b1; qcount_next = qcount + 1'b1;
                end
              end else begin
                rewind = 1'b1;
              end
              if (rewind) begin
                em.emit = 1'b1; em.kind = tdl_pkg::K_UNM;
                em.start = tdl_pkg::TOK_W'(tok_begin); em.len = 16'd1;
                qcount_next = '0;
                mstate_next = tdl_pkg::L_IDLE;
              end
            end

            default: mstate_next = tdl_pkg::L_IDLE;
          endcase

          if (consume) begin
            rd_n         = idx_inc(rd_idx);
            cur_pos_next = cur_pos + 1'b1;
          end
          if (rewind) begin
            rd_n         = idx_inc(qseq);
            cur_pos_next = tok_begin + 1'b1;
          end
          if (consume || rewind) begin
            rd_idx_next = rd_n;
            phase_next  = (rd_n != wr_idx) ? tdl_pkg::P_FETCH :
                          (eot ? tdl_pkg::P_FINAL : tdl_pkg::P_DONE);
          end
        end
      end

      tdl_pkg::P_FINAL: begin
        if (out_rdy) begin
          case (mstate)
            tdl_pkg::L_IDLE: phase_next = tdl_pkg::P_DONE;
            tdl_pkg::L_INT_DOT: begin
              // Number first; the trailing dot closes as a lone punctuation.
              em.emit = 1'b1; em.kind = tdl_pkg::K_NUM;
              em.start = tdl_pkg::TOK_W'(tok_begin); em.len = run_len;
              mstate_next    = tdl_pkg::L_LEAD_DOT;
              tok_begin_next = last_pos + 1'b1;
            end
            tdl_pkg::L_LEAD_DOT: begin
              em.emit = 1'b1; em.kind = tdl_pkg::K_PUNCT;
              em.start = tdl_pkg::TOK_W'(tok_begin); em.len = 16'd1;
              mstate_next = tdl_pkg::L_IDLE;
            end
            tdl_pkg::L_QUOTE: begin
              em.emit = 1'b1; em.kind = tdl_pkg::K_UNM;
              em.start = tdl_pkg::TOK_W'(tok_begin); em.len = 16'd1;
              qcount_next  = '0;
              mstate_next  = tdl_pkg::L_IDLE;
              rd_n         = idx_inc(qseq);
              rd_idx_next  = rd_n;
              cur_pos_next = tok_begin + 1'b1;
              phase_next   = (rd_n != wr_idx) ? tdl_pkg::P_FETCH : tdl_pkg::P_FINAL;
            end
            default: begin
              em.emit = 1'b1; em.kind = last_kind;
              em.start = tdl_pkg::TOK_W'(tok_begin); em.len = run_len;
              mstate_next = tdl_pkg::L_IDLE;
            end
          endcase
        end
      end

      tdl_pkg::P_DONE: begin
        if (out_rdy) begin
          em.done    = 1'b1;
          phase_next = tdl_pkg::P_WAIT;
          if (eot) begin
            cur_pos_next   = '0;
            tok_begin_next = '0;
            last_pos_next  = '0;
            run_len_next   = '0;
          end
        end
      end

      default: phase_next = tdl_pkg::P_WAIT;
    endcase
  end
endmodule

@@ src/tdl_out.sv @@
// Result stage: hold the newest token until the next one or the end of the
// item marks it, then drive it from the output register. Depends on tdl_pkg, tdl_if.
module tdl_out (
  input  logic           clk,
  input  logic           rst,
  input  tdl_pkg::emit_t em,
  output logic           out_rdy,
  tdl_tokens_if.source   tokens
);
  logic pend_v, out_v, out_free, last;
  tdl_pkg::kind_t kind, pend_kind;
  logic [tdl_pkg::TOK_W-1:0] start, len, pend_start, pend_len;

  assign out_free = !out_v || tokens.ready;
  assign out_rdy  = !pend_v || out_free;

  assign tokens.valid        = out_v;
  assign tokens.token_kind   = kind;
  assign tokens.token_start  = start;
  assign tokens.token_length = len;
  assign tokens.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_rdy && pend_v && (em.emit || em.done)) out_v <= 1'b1;
      else if (tokens.ready) out_v <= 1'b0;
      if (out_rdy && em.emit) pend_v <= 1'b1;
      else if (out_rdy && em.done) pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && em.emit) begin
      pend_kind  <= em.kind;
      pend_start <= em.start;
      pend_len   <= em.len;
    end
    if (out_rdy && pend_v && (em.emit || em.done)) begin
      kind  <= pend_kind;
      start <= pend_start;
      len   <= pend_len;
      last  <= em.done;
    end
  end
endmodule

@@ src/table_driven_text_lexer_unit.sv @@
// Longest-match text lexer. Characters arrive one per item on the chars
// channel; tokens leave on the tokens channel as kind, start and length, with
// last_of_run set on the final token an item causes. A front queue classifies
// characters and holds two items; the back core takes a new item only when it
// is through with the last one. In the core an item is loaded, stepped and
// closed, and at end of text open tokens are flushed before the close. A
// character that closes a token it does not join is stepped again; a character
// replayed from the class history RAM after a failed quote takes a registered
// read, then a step; tokens open at end of text close one by one (a number
// ending in a dot as the number, then the dot).
// The result stage holds the newest token until the next token or the end of
// the item, so a stalled tokens channel stalls the core. The history RAM holds
// REPLAY_DEPTH classes; quotes longer than that come out unmatched.
// Depends on tdl_pkg, tdl_if, tdl_front, tdl_core, tdl_out.
module table_driven_text_lexer_unit #(
  parameter int REPLAY_DEPTH = 32,
  parameter int POS_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst,
  tdl_chars_if.sink    chars,
  tdl_tokens_if.source tokens
);
  tdl_pkg::item_t item;
  tdl_pkg::emit_t em;
  logic item_valid, item_pop, out_rdy;

  // Accept and classify characters.
  tdl_front u_front (
    .clk, .rst, .chars, .item, .item_valid, .item_pop
  );

  // Step the token machines; replay after a failed quote.
  tdl_core #(.REPLAY_DEPTH(REPLAY_DEPTH), .POS_BITS(POS_BITS)) u_core (
    .clk, .rst, .item, .item_valid, .item_pop, .em, .out_rdy
  );

  // Mark the last token of each item and drive the output.
  tdl_out u_out (
    .clk, .rst, .em, .out_rdy, .tokens
  );
endmodule

@@ src/tdl_checker.sv @@
// Port-level checks of the lexer's token output, bound to the top level.
// Depends on tdl_pkg.
module tdl_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  token_kind,
  input logic [15:0] token_start,
  input logic [15:0] token_length,
  input logic        last_of_run
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(token_kind) && $stable(token_length) &&
                        $stable(token_start) && $stable(last_of_run))
    else $error("token changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    valid |-> token_kind <= 3'(tdl_pkg::K_UNM))
    else $error("bad token kind");

  a_unm_len: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind == 3'(tdl_pkg::K_UNM) |-> token_length == 16'd1)
    else $error("unmatched token longer than one");

  a_len: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind != 3'(tdl_pkg::K_WORD) |-> token_length != 16'd0)
    else $error("empty non-word token");
endmodule

bind table_driven_text_lexer_unit tdl_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .valid        (tokens.valid),
  .ready        (tokens.ready),
  .token_kind   (tokens.token_kind),
  .token_start  (tokens.token_start),
  .token_length (tokens.token_length),
  .last_of_run  (tokens.last_of_run)
);

@@ tb/table_driven_text_lexer_unit_tb.sv @@
// Testbench for the text lexer: drives character items, predicts the token
// stream in a behavioral lexer, and checks every token item field by field.
// Depends on tdl_pkg, tdl_if and table_driven_text_lexer_unit.
`timescale 1ns / 1ps

module table_driven_text_lexer_unit_tb;

  localparam int QUOTE_DEPTH = 32;
  localparam int MAX_TOKS    = 64;
  localparam int WORK_CAP    = 2 * QUOTE_DEPTH + 2;
  localparam int CYCLE_LIMIT = 5_000_000;

  // Character sets of the token machines.
  localparam string PUNCT_SET = ",.?!:;()\t";
  localparam string OPER_SET  = "*<>=";
  localparam string QBODY_SET = "_-+=,.?!:;()@#$%^&* ";
  localparam string WORD_SYMS = "_-";

  typedef struct {
    tdl_pkg::kind_t kind;
    logic [15:0]    start;
    logic [15:0]    len;
    logic           last;
  } token_t;

  logic clk;
  logic rst;

  tdl_chars_if  chars ();
  tdl_tokens_if tokens ();

  table_driven_text_lexer_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  // Tokens predicted and not yet seen on the output.
  token_t expected_tokens[$];
  int     errors = 0;
  int     cycles = 0;
  bit     sender_gaps;
  bit     sink_stalls;
  int     stall_left = 0;

  // Lexer state mirror.
  tdl_pkg::lex_state_t lex_st;
  logic [15:0]         tok_begin;
  logic [15:0]         scan_pos;
  logic [15:0]         accept_pos;
  tdl_pkg::kind_t      accept_kind;
  logic [7:0]          quote_buf[QUOTE_DEPTH];
  int                  quote_cnt;
  int                  run_len;
  logic [7:0]          pending[$];
  token_t              step_toks[$];

  // Text under construction for the next string.
  logic [7:0]  text[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Character classes
  // ------------------------------------------------------------------
  function automatic bit in_list(input logic [7:0] c, input string s);
    for (int i = 0; i < s.len(); i++)
      if (s[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return is_letter(c) || in_list(c, WORD_SYMS);
  endfunction

  function automatic bit is_quote(input logic [7:0] c);
    return c == 8'h22 || c == 8'h27;
  endfunction

  // ------------------------------------------------------------------
  // Token predictor
  // ------------------------------------------------------------------
  function automatic void add_token(input tdl_pkg::kind_t k, input logic [15:0] s,
                                    input int n);
    token_t t;
    if (step_toks.size() >= MAX_TOKS) return;
    t.kind  = k;
    t.start = s;
    t.len   = (n > 65535) ? 16'hFFFF : n[15:0];
    t.last  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void open_run(input tdl_pkg::kind_t k, input tdl_pkg::lex_state_t st,
                                   input logic [15:0] p);
    lex_st      = st;
    tok_begin   = p;
    accept_pos  = p;
    accept_kind = k;
    run_len     = 1;
  endfunction

  function automatic void grow_run(input logic [15:0] p);
    accept_pos = p;
    if (run_len < 65535) run_len++;
  endfunction

  function automatic void close_token();
    add_token(accept_kind, tok_begin, run_len);
    lex_st = tdl_pkg::L_IDLE;
  endfunction

  // Put bytes back at the head of the work list, up to its capacity.
  function automatic void requeue(input logic [7:0] b[$]);
    int k;
    if (pending.size() >= WORK_CAP) return;
    k = b.size();
    if (k > WORK_CAP - pending.size()) k = WORK_CAP - pending.size();
    for (int i = k - 1; i >= 0; i--) pending.push_front(b[i]);
  endfunction

  // Report the opening quote as unmatched; replay what followed it.
  function automatic void abandon_quote();
    int k;
    logic [7:0] b[$];
    k = (quote_cnt > QUOTE_DEPTH) ? QUOTE_DEPTH : quote_cnt;
    add_token(tdl_pkg::K_UNM, tok_begin, 1);
    for (int i = 1; i < k; i++) b.push_back(quote_buf[i]);
    if (b.size() > 0) requeue(b);
    scan_pos  = tok_begin + 16'd1;
    quote_cnt = 0;
    lex_st    = tdl_pkg::L_IDLE;
  endfunction

  // Returns 1 when the byte is consumed at the current position.
  function automatic bit lex_byte(input logic [7:0] c);
    logic [15:0] p;
    logic [7:0]  b[$];
    p = scan_pos;
    forever begin
      case (lex_st)
        tdl_pkg::L_IDLE: begin
          if (is_digit(c)) open_run(tdl_pkg::K_NUM, tdl_pkg::L_INT, p);
          else if (c == ".") open_run(tdl_pkg::K_PUNCT, tdl_pkg::L_LEAD_DOT, p);
          else if (is_word_char(c)) open_run(tdl_pkg::K_WORD, tdl_pkg::L_WORD, p);
          else if (c == " ") open_run(tdl_pkg::K_SPACE, tdl_pkg::L_SPACE, p);
          else if (in_list(c, PUNCT_SET)) open_run(tdl_pkg::K_PUNCT, tdl_pkg::L_PUNCT, p);
          else if (in_list(c, OPER_SET)) open_run(tdl_pkg::K_OPER, tdl_pkg::L_OPER, p);
          else if (is_quote(c)) begin
            lex_st       = tdl_pkg::L_QUOTE;
            tok_begin    = p;
            quote_buf[0] = c;
            quote_cnt    = 1;
          end else add_token(tdl_pkg::K_UNM, p, 1);
          return 1'b1;
        end
        tdl_pkg::L_INT: begin
          if (is_digit(c)) begin grow_run(p); return 1'b1; end
          if (c == ".") begin lex_st = tdl_pkg::L_INT_DOT; return 1'b1; end
          close_token();
        end
        tdl_pkg::L_INT_DOT: begin
          if (is_digit(c)) begin
            run_len    = (run_len + 2 > 65535) ? 65535 : run_len + 2;
            accept_pos = p;
            lex_st     = tdl_pkg::L_FRAC;
            return 1'b1;
          end
          // The dot was not a fraction: it opens a punctuation run.
          add_token(tdl_pkg::K_NUM, tok_begin, run_len);
          open_run(tdl_pkg::K_PUNCT, tdl_pkg::L_PUNCT, p - 16'd1);
        end
        tdl_pkg::L_LEAD_DOT: begin
          if (is_digit(c)) begin
            lex_st      = tdl_pkg::L_FRAC;
            accept_kind = tdl_pkg::K_NUM;
            accept_pos  = p;
            run_len     = 2;
            return 1'b1;
          end
          lex_st = tdl_pkg::L_PUNCT;
        end
        default: ;
      endcase
      case (lex_st)
        tdl_pkg::L_FRAC: begin
          if (is_digit(c)) begin grow_run(p); return 1'b1; end
          close_token();
        end
        tdl_pkg::L_WORD: begin
          if (is_word_char(c)) begin grow_run(p); return 1'b1; end
          close_token();
        end
        tdl_pkg::L_SPACE: begin
          if (c == " ") begin grow_run(p); return 1'b1; end
          close_token();
        end
        tdl_pkg::L_PUNCT: begin
          if (in_list(c, PUNCT_SET)) begin grow_run(p); return 1'b1; end
          close_token();
        end
        tdl_pkg::L_OPER: begin
          if (in_list(c, OPER_SET)) begin grow_run(p); return 1'b1; end
          close_token();
        end
        tdl_pkg::L_QUOTE: begin
          if (is_quote(c)) begin
            add_token(tdl_pkg::K_WORD, tok_begin + 16'd1,
                      (quote_cnt > 0) ? quote_cnt - 1 : 0);
            quote_cnt = 0;
            lex_st    = tdl_pkg::L_IDLE;
            return 1'b1;
          end
          if (is_letter(c) || in_list(c, QBODY_SET)) begin
            if (quote_cnt < QUOTE_DEPTH) quote_buf[quote_cnt] = c;
            quote_cnt++;
            // A full buffer means the quote is too long to hold.
            if (quote_cnt >= QUOTE_DEPTH) begin
              abandon_quote();
              return 1'b0;
            end
            return 1'b1;
          end
          b.push_back(c);
          requeue(b);
          abandon_quote();
          return 1'b0;
        end
        tdl_pkg::L_IDLE, tdl_pkg::L_INT, tdl_pkg::L_INT_DOT, tdl_pkg::L_LEAD_DOT: ;
        default: lex_st = tdl_pkg::L_IDLE;
      endcase
    end
  endfunction

  // Close whatever is open when the text ends.
  function automatic void close_at_end();
    case (lex_st)
      tdl_pkg::L_INT_DOT: begin
        add_token(tdl_pkg::K_NUM, tok_begin, run_len);
        add_token(tdl_pkg::K_PUNCT, accept_pos + 16'd1, 1);
        lex_st = tdl_pkg::L_IDLE;
      end
      tdl_pkg::L_LEAD_DOT: begin
        add_token(tdl_pkg::K_PUNCT, tok_begin, 1);
        lex_st = tdl_pkg::L_IDLE;
      end
      tdl_pkg::L_QUOTE: abandon_quote();
      tdl_pkg::L_IDLE: ;
      default: close_token();
    endcase
  endfunction

  // Work out the tokens one accepted character causes.
  function automatic void predict_tokens(input logic [7:0] c, input bit eot);
    logic [7:0] nxt;
    step_toks.delete();
    pending.delete();
    pending.push_back(c);
    forever begin
      while (pending.size() > 0) begin
        nxt = pending.pop_front();
        if (lex_byte(nxt)) scan_pos = scan_pos + 16'd1;
      end
      if (!eot || lex_st == tdl_pkg::L_IDLE) break;
      close_at_end();
    end
    if (eot) begin
      scan_pos   = '0;
      tok_begin  = '0;
      accept_pos = '0;
      run_len    = 0;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  // ------------------------------------------------------------------
  // Token checker and sink stalls
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    token_t want;
    if (!rst && tokens.valid && tokens.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d", tokens.token_kind,
               tokens.token_start, tokens.token_length);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (tokens.token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, tokens.token_kind);
          errors++;
        end
        if (tokens.token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, tokens.token_start);
          errors++;
        end
        if (tokens.token_length !== want.len) begin
          $error("token_length: expected %0d, got %0d", want.len, tokens.token_length);
          errors++;
        end
        if (tokens.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, tokens.last_of_run);
          errors++;
        end
      end
    end
  end

  // Hold ready low in bursts of random length while stalls are enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      tokens.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(1, 15) - 1;
      tokens.ready <= 1'b0;
    end else begin
      tokens.ready <= 1'b1;
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sending
  // ------------------------------------------------------------------
  // Send one character item; predict its tokens at acceptance.
  task automatic send_char(input logic [7:0] c, input bit eot);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      chars.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    chars.valid       <= 1'b1;
    chars.char_code   <= c;
    chars.end_of_text <= eot;
    do @(posedge clk); while (!chars.ready);
    predict_tokens(c, eot);
  endtask

  // Send the built-up text as one string, end flag on its last byte.
  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_quote_body();
    return $urandom_range(0, 1) ? rand_letter() : pick(QBODY_SET);
  endfunction

  function automatic logic [7:0] rand_quote();
    return $urandom_range(0, 1) ? 8'h22 : 8'h27;
  endfunction

  // Append one random lexeme, mostly well formed.
  function automatic void put_lexeme();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        if ($urandom_range(0, 3) == 0) text.push_back(".");
        else repeat ($urandom_range(1, 4)) text.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          text.push_back(".");
          repeat ($urandom_range(0, 3)) text.push_back(rand_digit());
        end
      end
      3, 4, 5: repeat ($urandom_range(1, 5))
        text.push_back($urandom_range(0, 4) == 0 ? pick(WORD_SYMS) : rand_letter());
      6, 7:    repeat ($urandom_range(1, 3)) text.push_back(" ");
      8, 9:    repeat ($urandom_range(1, 3)) text.push_back(pick(PUNCT_SET));
      10, 11:  repeat ($urandom_range(1, 3)) text.push_back(pick(OPER_SET));
      12, 13, 14: begin
        text.push_back(rand_quote());
        repeat ($urandom_range(0, 6)) text.push_back(rand_quote_body());
        text.push_back(rand_quote());
      end
      15, 16: begin
        // Broken quote: a byte outside the quotable set, or no closing byte of its own.
        text.push_back(rand_quote());
        repeat ($urandom_range(0, 4)) text.push_back(rand_quote_body());
        if ($urandom_range(0, 2) != 0)
          text.push_back($urandom_range(0, 1) ? rand_digit() : pick("<>\t~"));
      end
      17: begin
        // Quote around the buffer size: some fit, some overflow.
        n = $urandom_range(28, 34);
        text.push_back(rand_quote());
        repeat (n) text.push_back(rand_quote_body());
        text.push_back(rand_quote());
      end
      default: text.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void build_string(input int max_lex);
    repeat ($urandom_range(1, max_lex)) put_lexeme();
  endfunction

  task automatic wait_drained();
    chars.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    // Items with no token may still be in flight; let them finish.
    repeat (40) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Extremes and special cases, one short string each.
  task automatic test_special_cases();
    put_str("12.");                                        send_text();
    text.push_back(8'h00); put_str("x"); text.push_back(8'hFF); send_text();
    put_str("'a b'");                                      send_text();
    text.push_back(8'h22); text.push_back(8'h22);           send_text();
    put_str("'a%<");                                       send_text();
    put_str("<=*\t");                                      send_text();
    put_str(".!9 _-");                                     send_text();
  endtask

  // Quote that overruns the history buffer.
  task automatic test_long_quote();
    text.push_back(8'h27);
    repeat (QUOTE_DEPTH + 2) text.push_back("q");
    text.push_back(8'h27);
    send_text();
  endtask

  // Random strings; pause once until the token stream has drained.
  task automatic test_random_text(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      build_string(8);
      len = text.size();
      sent += len;
      send_text();
      if (sent > n_items / 2 && sent - len <= n_items / 2) wait_drained();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (4) begin
      build_string(5);
      send_text();
    end
  endtask

  initial begin
    sender_gaps       = 1'b1;
    sink_stalls       = 1'b1;
    rst               = 1'b1;
    chars.valid       = 1'b0;
    chars.char_code   = '0;
    chars.end_of_text = 1'b0;
    lex_st            = tdl_pkg::L_IDLE;
    tok_begin         = '0;
    scan_pos          = '0;
    accept_pos        = '0;
    accept_kind       = tdl_pkg::K_NUM;
    quote_cnt         = 0;
    run_len           = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_long_quote();
    test_random_text(160);
    wait_drained();
    test_random_text(130);
    test_full_rate();

    chars.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
